>>> sv/ubxr_pkg.sv
// Shared types and constants for the UBX frame position rotator.
// Used by ubxr_rotate and ubx_frame_position_rotator; depends on nothing.
package ubxr_pkg;

    localparam int BUF_DEPTH_DEF = 256;
    // byte index width: holds payload_len + 8 and the deepest buffer
    localparam int IDX_W         = 10;

    localparam logic [7:0] SYNC_ONE = 8'hB5;
    localparam logic [7:0] SYNC_TWO = 8'h62;

    localparam int POS_AT      = 18;   // x word at 18..21, y word at 22..25
    localparam int SUM_START   = 2;
    localparam int REWRITE_END = 58;
    localparam int REWRITE_LEN = 60;
    localparam int FRAME_OVH   = 8;
    localparam int PACK_BYTES  = 8;

    // x/100 for x < 2^32 is (x * MAGIC) >> 37
    localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
    localparam int          DIV100_SHIFT = 37;
    localparam int          Q_SHIFT      = 30;

    localparam logic [7:0]  MATCH_CLASS_RST = 8'd1;
    localparam logic [7:0]  REWRITE_ID_RST  = 8'd6;
    localparam logic [31:0] ROT_COS_RST     = 32'd690187937;
    localparam logic [31:0] ROT_SIN_RST     = 32'd822533957;

    localparam logic [1:0] REG_MATCH_CLASS = 2'd0;
    localparam logic [1:0] REG_REWRITE_ID  = 2'd1;
    localparam logic [1:0] REG_ROT_COS     = 2'd2;
    localparam logic [1:0] REG_ROT_SIN     = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_RREAD,
        ST_ROT,
        ST_WB,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        HS_SYNC1,
        HS_SYNC2,
        HS_CLASS,
        HS_ID,
        HS_LENL,
        HS_LENH,
        HS_PAY,
        HS_CSUM
    } t_hunt;

endpackage

>>> sv/ubx_frame_position_rotator.sv
// UBX frame parser with frame buffer, position rotation and Fletcher-8 re-emission.
// Depends on ubxr_pkg and ubxr_rotate.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  rx      | in        | i_valid / o_stall    | i_rx_byte
//  out     | out       | o_valid / i_stall    | o_out_bytes, o_byte_count, o_frame_end
//  cfg     | in        | i_cfg_we             | i_cfg_index, i_cfg_data
//
// One rx item per cycle while parsing. At a frame end the buffer memory is replayed byte by
// byte through its single read port into eight-byte output items, pausing at each item and
// while the output is stalled; a rewrite frame first reads, rotates and writes back its
// position words, then emits its 60 bytes. After reset a clearing pass zeroes the buffer;
// rx is stalled meanwhile and during replay. The output register lets rx resume while the last item waits.
module ubx_frame_position_rotator
    import ubxr_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_out_bytes,
    output logic [3:0]  o_byte_count,
    output logic        o_frame_end,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int AW = $clog2(BUF_DEPTH);

    logic [7:0]  r_match_class, r_rewrite_id;
    logic [31:0] r_rot_cos, r_rot_sin;

    t_state r_state, n_state;
    t_hunt  r_hunt, n_hunt;
    logic [8:0] r_count, n_count;
    logic [7:0] r_msg_id, n_msg_id;
    logic [7:0] r_len, n_len;

    logic [AW-1:0] r_clr;
    logic [3:0]    r_cnt;
    logic          r_rvld;
    logic [63:0]   r_xy;

    logic [7:0]  mem [BUF_DEPTH];
    logic        mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [7:0]  mem_wd, r_rdata;

    // frame-end replay
    logic             r_rw;
    logic [IDX_W-1:0] r_end, r_rd_idx, r_rd_didx;
    logic             r_rd_vld;
    logic [63:0]      r_pk;
    logic [3:0]       r_pk_cnt;
    logic [7:0]       r_sum_a, r_sum_b;
    logic             r_o_valid;
    logic [63:0]      r_o_bytes;
    logic [3:0]       r_o_count;
    logic             r_o_end;

    logic             rx_acc, wen, frame_done, overlong, is_rw;
    logic [IDX_W-1:0] widx;
    logic             em_issue, em_last, em_flush, out_free;
    logic [7:0]       em_byte, sa_next;
    logic             rot_start, rot_done;
    logic [31:0]      rot_x, rot_y;
    logic [63:0]      wb_word;

    ubxr_rotate u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rot_start),
        .i_pos_x (r_xy[31:0]),
        .i_pos_y (r_xy[63:32]),
        .i_cos   (r_rot_cos),
        .i_sin   (r_rot_sin),
        .o_done  (rot_done),
        .o_pos_x (rot_x),
        .o_pos_y (rot_y)
    );

    assign wb_word = {rot_y, rot_x};

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_class <= MATCH_CLASS_RST;
            r_rewrite_id  <= REWRITE_ID_RST;
            r_rot_cos     <= ROT_COS_RST;
            r_rot_sin     <= ROT_SIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MATCH_CLASS: r_match_class <= i_cfg_data[7:0];
                REG_REWRITE_ID:  r_rewrite_id  <= i_cfg_data[7:0];
                REG_ROT_COS:     r_rot_cos     <= i_cfg_data;
                REG_ROT_SIN:     r_rot_sin     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign rx_acc = i_valid && !o_stall;

    // header hunt and payload capture
    always_comb begin
        n_hunt     = r_hunt;
        n_count    = r_count;
        n_msg_id   = r_msg_id;
        n_len      = r_len;
        wen        = 1'b0;
        widx       = '0;
        frame_done = 1'b0;
        unique case (r_hunt)
            HS_SYNC1: begin
                widx = IDX_W'(0);
                if (i_rx_byte == SYNC_ONE) begin wen = 1'b1; n_hunt = HS_SYNC2; end
            end
            HS_SYNC2: begin
                widx = IDX_W'(1);
                if (i_rx_byte == SYNC_TWO) begin wen = 1'b1; n_hunt = HS_CLASS; end
                else n_hunt = HS_SYNC1;
            end
            HS_CLASS: begin
                widx = IDX_W'(2);
                if (i_rx_byte == r_match_class) begin wen = 1'b1; n_hunt = HS_ID; end
                else n_hunt = HS_SYNC1;
            end
            HS_ID: begin
                widx = IDX_W'(3); wen = 1'b1; n_msg_id = i_rx_byte; n_hunt = HS_LENL;
            end
            HS_LENL: begin
                widx = IDX_W'(4); wen = 1'b1; n_len = i_rx_byte; n_hunt = HS_LENH;
            end
            HS_LENH: begin
                widx = IDX_W'(5);
                if (i_rx_byte == 8'd0) begin
                    wen = 1'b1; n_count = 9'd0; n_hunt = HS_PAY;
                end else n_hunt = HS_SYNC1;
            end
            HS_PAY: begin
                widx    = IDX_W'(6) + IDX_W'(r_count);
                wen     = 1'b1;
                n_count = r_count + 9'd1;
                if (n_count == ({1'b0, r_len} + 9'd1)) n_hunt = HS_CSUM;
            end
            HS_CSUM: begin
                widx       = IDX_W'(r_len) + IDX_W'(7);
                wen        = 1'b1;
                frame_done = 1'b1;
                n_hunt     = HS_SYNC1;
                n_count    = 9'd0;
                n_msg_id   = 8'd0;
                n_len      = 8'd0;
            end
            default: n_hunt = HS_SYNC1;
        endcase
    end

    assign overlong = (IDX_W'(r_len) + IDX_W'(FRAME_OVH)) > IDX_W'(BUF_DEPTH);
    assign is_rw    = (r_msg_id == r_rewrite_id);

    // replay sequencing
    assign out_free = !r_o_valid || !i_stall;
    assign em_issue = (r_state == ST_EMIT) && (r_rd_idx < r_end)
                      && ((r_pk_cnt + {3'd0, r_rd_vld}) < 4'(PACK_BYTES));
    assign em_last  = (r_rd_idx == r_end) && !r_rd_vld;
    assign em_flush = (r_state == ST_EMIT) && out_free
                      && ((r_pk_cnt == 4'(PACK_BYTES)) || (em_last && r_pk_cnt != 4'd0));
    assign rot_start = (r_state == ST_RREAD) && (r_cnt == 4'd8) && !r_rvld;

    always_comb begin
        if (r_rw && r_rd_didx == IDX_W'(REWRITE_END)) em_byte = r_sum_a;
        else if (r_rw && r_rd_didx == IDX_W'(REWRITE_END + 1)) em_byte = r_sum_b;
        else em_byte = r_rdata;
        sa_next = r_sum_a + em_byte;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == AW'(BUF_DEPTH - 1)) n_state = ST_RUN;
            ST_RUN: begin
                if (rx_acc && frame_done && !overlong)
                    n_state = is_rw ? ST_RREAD : ST_EMIT;
            end
            ST_RREAD: if (rot_start) n_state = ST_ROT;
            ST_ROT:   if (rot_done) n_state = ST_WB;
            ST_WB:    if (r_cnt == 4'd7) n_state = ST_EMIT;
            ST_EMIT:  if (em_flush && em_last) n_state = ST_RUN;
            default:  n_state = ST_RUN;
        endcase
    end

    // outputs of the state machine: stall and memory ports
    always_comb begin
        o_stall = 1'b1;
        mem_we  = 1'b0;
        mem_wa  = '0;
        mem_wd  = 8'd0;
        mem_re  = 1'b0;
        mem_ra  = '0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1; mem_wa = r_clr;
            end
            ST_RUN: begin
                o_stall = 1'b0;
                mem_we  = rx_acc && wen && (widx < IDX_W'(BUF_DEPTH));
                mem_wa  = widx[AW-1:0];
                mem_wd  = i_rx_byte;
            end
            ST_RREAD: begin
                mem_re = (r_cnt < 4'd8);
                mem_ra = AW'(POS_AT) + AW'(r_cnt[2:0]);
            end
            ST_WB: begin
                mem_we = 1'b1;
                mem_wa = AW'(POS_AT) + AW'(r_cnt[2:0]);
                mem_wd = wb_word[r_cnt[2:0]*8 +: 8];
            end
            ST_EMIT: begin
                mem_re = em_issue && !(r_rw && r_rd_idx >= IDX_W'(REWRITE_END));
                mem_ra = r_rd_idx[AW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (mem_re) r_rdata <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_hunt   <= HS_SYNC1;
            r_count  <= 9'd0;
            r_msg_id <= 8'd0;
            r_len    <= 8'd0;
            r_clr    <= '0;
            r_cnt    <= 4'd0;
            r_rvld   <= 1'b0;
            r_rw     <= 1'b0;
            r_end    <= '0;
            r_rd_idx <= '0;
            r_rd_vld <= 1'b0;
            r_pk_cnt <= 4'd0;
            r_sum_a  <= 8'd0;
            r_sum_b  <= 8'd0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + AW'(1);
            if (rx_acc) begin
                r_hunt   <= n_hunt;
                r_count  <= n_count;
                r_msg_id <= n_msg_id;
                r_len    <= n_len;
                if (frame_done) begin
                    r_rw  <= is_rw;
                    r_end <= is_rw ? IDX_W'(REWRITE_LEN) : (IDX_W'(r_len) + IDX_W'(FRAME_OVH));
                end
            end

            // counter shared by position read and write-back
            r_rvld <= mem_re && (r_state == ST_RREAD);
            if (r_state == ST_RREAD || r_state == ST_WB) begin
                if (r_cnt < 4'd8) r_cnt <= r_cnt + 4'd1;
            end else begin
                r_cnt <= 4'd0;
            end

            if (r_state != ST_EMIT) begin
                r_rd_idx <= '0;
                r_rd_vld <= 1'b0;
                r_pk_cnt <= 4'd0;
                r_sum_a  <= 8'd0;
                r_sum_b  <= 8'd0;
            end else begin
                r_rd_vld <= em_issue;
                if (em_issue) r_rd_idx <= r_rd_idx + IDX_W'(1);
                if (r_rd_vld) begin
                    r_pk_cnt <= r_pk_cnt + 4'd1;
                    if (r_rw && r_rd_didx >= IDX_W'(SUM_START)
                        && r_rd_didx < IDX_W'(REWRITE_END)) begin
                        r_sum_a <= sa_next;
                        r_sum_b <= r_sum_b + sa_next;
                    end
                end else if (em_flush) begin
                    r_pk_cnt <= 4'd0;
                end
            end

            if (em_flush) r_o_valid <= 1'b1;
            else if (!i_stall) r_o_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_rvld) r_xy <= {r_rdata, r_xy[63:8]};
        if (em_issue) r_rd_didx <= r_rd_idx;
        if (r_state != ST_EMIT || em_flush) begin
            r_pk <= 64'd0;
        end else if (r_rd_vld) begin
            r_pk[r_pk_cnt[2:0]*8 +: 8] <= em_byte;
        end
        if (em_flush) begin
            r_o_bytes <= r_pk;
            r_o_count <= r_pk_cnt;
            r_o_end   <= em_last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_out_bytes  = r_o_bytes;
    assign o_byte_count = r_o_count;
    assign o_frame_end  = r_o_end;

`ifndef SYNTHESIS
    a_pack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pk_cnt + {3'd0, r_rd_vld}) <= 4'(PACK_BYTES))
        else $error("pack register overfilled");
    a_full_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (em_flush && !em_last) |-> (r_pk_cnt == 4'(PACK_BYTES)))
        else $error("short item before frame end");
    a_out_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> (o_byte_count != 4'd0 && o_byte_count <= 4'(PACK_BYTES)))
        else $error("bad byte count on output item");
    a_no_rx_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |=> !(mem_we && r_state == ST_RUN && $past(em_issue) && !em_last))
        else $error("rx write during replay");
`endif

endmodule

>>> sv/ubxr_rotate.sv
// Q2.30 rotation of one x/y position pair around a single shared multiplier.
// Takes ubxr_pkg for the divide-by-100 constants.
module ubxr_rotate
    import ubxr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_pos_x,   // held by the caller while busy
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_cos,
    input  logic [31:0] i_sin,
    output logic        o_done,
    output logic [31:0] o_pos_x,
    output logic [31:0] o_pos_y
);

    logic               r_busy;
    logic [2:0]         r_step;
    logic               r_done;
    logic signed [32:0] r_qx, r_qy;
    logic signed [63:0] r_acc, r_dx, r_dy;
    logic [31:0]        r_xo, r_yo;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic [31:0]        src, src_abs;
    logic               src_neg;
    logic signed [32:0] q_pos;

    // 100 * d / 2^30, truncated toward zero, saturated to 32 bits
    function automatic logic [31:0] scale_sat(input logic signed [63:0] d);
        logic signed [63:0] t;
        logic signed [63:0] u;
        logic [31:0]        res;
        t = (d <<< 6) + (d <<< 5) + (d <<< 2);
        u = (t + (t[63] ? 64'sd1073741823 : 64'sd0)) >>> Q_SHIFT;
        if (u > 64'sd2147483647) begin
            res = 32'h7FFF_FFFF;
        end else if (u < -64'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = u[31:0];
        end
        return res;
    endfunction

    always_comb begin
        src     = (r_step == 3'd0) ? i_pos_x : i_pos_y;
        src_neg = src[31];
        src_abs = src_neg ? (32'd0 - src) : src;
        mul_a   = 33'sd0;
        mul_b   = 33'sd0;
        case (r_step)
            3'd0, 3'd1: begin
                mul_a = $signed({1'b0, src_abs});
                mul_b = $signed({1'b0, DIV100_MAGIC});
            end
            3'd2: begin mul_a = r_qx; mul_b = $signed({i_cos[31], i_cos}); end
            3'd3: begin mul_a = r_qy; mul_b = $signed({i_sin[31], i_sin}); end
            3'd4: begin mul_a = r_qx; mul_b = $signed({i_sin[31], i_sin}); end
            3'd5: begin mul_a = r_qy; mul_b = $signed({i_cos[31], i_cos}); end
            default: begin mul_a = 33'sd0; mul_b = 33'sd0; end
        endcase
        prod  = mul_a * mul_b;
        q_pos = $signed({7'd0, prod[62:DIV100_SHIFT]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 3'd0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            case (r_step)
                3'd0: r_qx  <= src_neg ? -q_pos : q_pos;
                3'd1: r_qy  <= src_neg ? -q_pos : q_pos;
                3'd2: r_acc <= prod[63:0];
                3'd3: r_dx  <= r_acc - prod[63:0];
                3'd4: r_acc <= prod[63:0];
                3'd5: r_dy  <= r_acc + prod[63:0];
                3'd6: r_xo  <= scale_sat(r_dx);
                default: r_yo <= scale_sat(r_dy);
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_pos_x = r_xo;
    assign o_pos_y = r_yo;

endmodule
